// File: rtl/assert_macros.svh
// Shared concurrent assertion macros; clk and arst_n come from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/steim_pkg.sv
`default_nettype none
package steim_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int VERSION_RESET = 1;
	localparam int SAMPLE_COUNT_RESET = 1;

	localparam logic REG_VERSION = 1'b0;
	localparam logic REG_SAMPLE_COUNT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_BAD_WORD = 2'd1,
		STATUS_SHORT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_START,
		KIND_DATA,
		KIND_BAD
	} kind_t;

	typedef enum logic [3:0] {
		FMT_8X4,
		FMT_16X2,
		FMT_32X1,
		FMT_30X1,
		FMT_15X2,
		FMT_10X3,
		FMT_6X5,
		FMT_5X6,
		FMT_4X7
	} fmt_t;

	typedef struct packed {
		kind_t kind;
		fmt_t fmt;
		logic [31:0] word;
		logic eor;
	} cmd_t;

	function automatic logic [2:0] fmt_count(fmt_t fmt);
		case (fmt)
			FMT_8X4: return 3'd4;
			FMT_16X2: return 3'd2;
			FMT_32X1: return 3'd1;
			FMT_30X1: return 3'd1;
			FMT_15X2: return 3'd2;
			FMT_10X3: return 3'd3;
			FMT_6X5: return 3'd5;
			FMT_5X6: return 3'd6;
			FMT_4X7: return 3'd7;
			default: return 3'd1;
		endcase
	endfunction

	function automatic logic [5:0] fmt_bits(fmt_t fmt);
		case (fmt)
			FMT_8X4: return 6'd8;
			FMT_16X2: return 6'd16;
			FMT_32X1: return 6'd32;
			FMT_30X1: return 6'd30;
			FMT_15X2: return 6'd15;
			FMT_10X3: return 6'd10;
			FMT_6X5: return 6'd6;
			FMT_5X6: return 6'd5;
			FMT_4X7: return 6'd4;
			default: return 6'd32;
		endcase
	endfunction

	function automatic logic [5:0] fmt_top(fmt_t fmt);
		case (fmt)
			FMT_8X4, FMT_16X2, FMT_32X1: return 6'd32;
			FMT_4X7: return 6'd28;
			default: return 6'd30;
		endcase
	endfunction

	// Move field k to the top, then sign-extend it back down.
	function automatic logic [31:0] fmt_diff(logic [31:0] word, fmt_t fmt, logic [2:0] k);
		logic [7:0] lsh;
		logic [5:0] rsh;
		logic [31:0] moved;
		lsh = 8'd32 - {2'b00, fmt_top(fmt)} + {2'b00, fmt_bits(fmt)} * {5'b00000, k};
		rsh = 6'd32 - fmt_bits(fmt);
		moved = word << lsh[4:0];
		return 32'($signed(moved) >>> rsh[4:0]);
	endfunction

endpackage
`default_nettype wire

// File: rtl/steim_in_if.sv
`default_nettype none
interface steim_in_if;
	logic valid;
	logic ready;
	logic [31:0] data_word;
	logic end_of_record;

	modport source(output valid, data_word, end_of_record, input ready);
	modport sink(input valid, data_word, end_of_record, output ready);
endinterface
`default_nettype wire

// File: rtl/steim_out_if.sv
`default_nettype none
interface steim_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] sample;
	logic has_sample;
	logic record_done;
	logic [1:0] status;

	modport source(output valid, sample, has_sample, record_done, status, input ready);
	modport sink(input valid, sample, has_sample, record_done, status, output ready);
endinterface
`default_nettype wire

// File: rtl/steim_front.sv
`default_nettype none
module steim_front (
	input wire logic clk,
	input wire logic arst_n,
	steim_in_if.sink words,
	input wire logic steim_version,
	input wire logic queue_full,
	output logic push,
	output steim_pkg::cmd_t cmd
);
	import steim_pkg::*;

	logic [3:0] word_in_frame_q;
	logic in_first_frame_q;
	logic [31:0] control_q;
	logic [1:0] nib;
	logic [1:0] dnib;

	assign words.ready = !queue_full;
	assign push = words.valid && words.ready;
	assign nib = control_q[{~word_in_frame_q, 1'b0} +: 2];
	assign dnib = words.data_word[31:30];

	always_comb begin
		cmd.word = words.data_word;
		cmd.eor = words.end_of_record;
		cmd.kind = KIND_NONE;
		cmd.fmt = FMT_8X4;
		if (word_in_frame_q == 4'd0) begin
			cmd.kind = KIND_NONE;
		end else if (in_first_frame_q && word_in_frame_q == 4'd1) begin
			cmd.kind = KIND_START;
		end else if (in_first_frame_q && word_in_frame_q == 4'd2) begin
			cmd.kind = KIND_NONE;
		end else if (nib == 2'd1) begin
			cmd.kind = KIND_DATA;
			cmd.fmt = FMT_8X4;
		end else if (nib != 2'd0) begin
			cmd.kind = KIND_DATA;
			if (!steim_version) begin
				cmd.fmt = (nib == 2'd2) ? FMT_16X2 : FMT_32X1;
			end else if (nib == 2'd2) begin
				case (dnib)
					2'd1: cmd.fmt = FMT_30X1;
					2'd2: cmd.fmt = FMT_15X2;
					2'd3: cmd.fmt = FMT_10X3;
					default: cmd.kind = KIND_BAD;
				endcase
			end else begin
				case (dnib)
					2'd0: cmd.fmt = FMT_6X5;
					2'd1: cmd.fmt = FMT_5X6;
					2'd2: cmd.fmt = FMT_4X7;
					default: cmd.kind = KIND_BAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_in_frame_q <= 4'd0;
			in_first_frame_q <= 1'b1;
			control_q <= 32'd0;
		end else if (push) begin
			if (words.end_of_record) begin
				word_in_frame_q <= 4'd0;
				in_first_frame_q <= 1'b1;
				control_q <= 32'd0;
			end else begin
				word_in_frame_q <= word_in_frame_q + 4'd1;
				if (word_in_frame_q == 4'd15) begin
					in_first_frame_q <= 1'b0;
				end
				if (word_in_frame_q == 4'd0) begin
					control_q <= words.data_word;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/steim_queue.sv
`default_nettype none
module steim_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input steim_pkg::cmd_t push_cmd,
	input wire logic pop,
	output logic full,
	output logic head_valid,
	output steim_pkg::cmd_t head
);
	import steim_pkg::*;

	`include "assert_macros.svh"

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0] count_q;

	assign full = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= (PW+1)'(QUEUE_DEPTH), "queue count overflow")
	`ASSERT_IMPLY(a_pop_nonempty, pop, head_valid, "pop from empty queue")

endmodule
`default_nettype wire

// File: rtl/steim_back.sv
`default_nettype none
module steim_back #(
	parameter int COUNT_BITS = steim_pkg::COUNT_BITS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input steim_pkg::cmd_t head,
	output logic pop,
	input wire logic [15:0] sample_count,
	steim_out_if.source samples
);
	import steim_pkg::*;

	`include "assert_macros.svh"

	localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic error_q;
	logic [COUNT_BITS-1:0] emitted_q;
	logic first_used_q;
	logic [31:0] prior_q;
	logic [31:0] start_q;
	logic [2:0] k_q;

	logic out_valid_q;
	logic [31:0] sample_q;
	logic has_sample_q;
	logic record_done_q;
	status_t status_q;

	logic out_free;
	logic fire;
	logic active;
	logic emit;
	logic last_sample;
	logic done;
	logic produce;
	logic error_next;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [CW-1:0] emitted_x;
	logic [CW-1:0] next_x;
	logic [CW-1:0] final_x;
	logic [CW-1:0] limit_x;
	logic [31:0] sample_value;
	status_t status_value;

	assign out_free = !out_valid_q || samples.ready;
	assign fire = head_valid && out_free;

	assign emitted_x = CW'(emitted_q);
	assign cnt_next = emitted_q + 1'b1;
	assign next_x = CW'(cnt_next);
	assign limit_x = CW'(sample_count);

	assign active = !error_q && head.kind == KIND_DATA && emitted_x < limit_x && !(&emitted_q);
	assign emit = fire && active;
	assign last_sample = (k_q + 3'd1 == fmt_count(head.fmt)) || (next_x >= limit_x)
		|| (&cnt_next);
	assign pop = fire && (!active || last_sample);
	assign done = pop && head.eor;
	assign produce = emit || done;

	assign error_next = error_q || (head.kind == KIND_BAD && emitted_x < limit_x);
	assign final_x = emit ? next_x : emitted_x;
	assign sample_value = first_used_q ? prior_q + fmt_diff(head.word, head.fmt, k_q) : start_q;

	always_comb begin
		if (error_next) begin
			status_value = STATUS_BAD_WORD;
		end else if (final_x < limit_x) begin
			status_value = STATUS_SHORT;
		end else begin
			status_value = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q <= 1'b0;
			emitted_q <= '0;
			first_used_q <= 1'b0;
			prior_q <= 32'd0;
			start_q <= 32'd0;
			k_q <= 3'd0;
		end else if (fire) begin
			if (done) begin
				error_q <= 1'b0;
				emitted_q <= '0;
				first_used_q <= 1'b0;
				prior_q <= 32'd0;
				start_q <= 32'd0;
				k_q <= 3'd0;
			end else begin
				error_q <= error_next;
				if (head.kind == KIND_START && !error_q) begin
					start_q <= head.word;
				end
				if (emit) begin
					prior_q <= sample_value;
					emitted_q <= cnt_next;
					first_used_q <= 1'b1;
					k_q <= last_sample ? 3'd0 : k_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			sample_q <= emit ? sample_value : 32'd0;
			has_sample_q <= emit;
			record_done_q <= done;
			status_q <= done ? status_value : STATUS_OK;
		end
	end

	assign samples.valid = out_valid_q;
	assign samples.sample = $signed(sample_q);
	assign samples.has_sample = has_sample_q;
	assign samples.record_done = record_done_q;
	assign samples.status = status_q;

	`ASSERT_IMPLY(a_empty_is_done, out_valid_q && !has_sample_q, record_done_q,
		"result without sample must close the record")
	`ASSERT_IMPLY(a_status_at_done, out_valid_q && !record_done_q, status_q == STATUS_OK,
		"status set outside record end")

endmodule
`default_nettype wire

// File: rtl/steim_record_decoder_top.sv
`default_nettype none
// Steim-1/Steim-2 record decoder. Record words enter on the words channel, one
// transaction per 32-bit word, and reconstructed samples leave on the samples
// channel, one result per transaction. The front end takes one word per cycle
// while its four-entry queue has room; the back end retires one queued word per
// cycle while the samples channel is not stalled, except that a word unpacking
// into n samples stays at the queue head until all n are out (up to seven, for a
// Steim-2 word of seven 4-bit differences). A word's first result passes through
// its queue entry and then the output register before it is valid.
// record_done and status (0 ok, 1 bad word seen, 2 short record) ride on the last
// result of the end-of-record word; when that word yields no sample, it yields one
// result without a sample. Registers: steim_version at address 0, sample_count at
// address 4; write them only while the block is idle.
module steim_record_decoder_top #(
	parameter int COUNT_BITS = steim_pkg::COUNT_BITS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	steim_in_if.sink words,
	steim_out_if.source samples,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import steim_pkg::*;

	logic steim_version_q;
	logic [15:0] sample_count_q;
	logic cfg_write;

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic head_valid;
	cmd_t head;
	logic pop;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_SAMPLE_COUNT) ? {16'd0, sample_count_q}
		: {31'd0, steim_version_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steim_version_q <= 1'(VERSION_RESET);
			sample_count_q <= 16'(SAMPLE_COUNT_RESET);
		end else if (cfg_write) begin
			case (paddr[2])
				REG_VERSION: steim_version_q <= pwdata[0];
				REG_SAMPLE_COUNT: sample_count_q <= pwdata[15:0];
				default: sample_count_q <= sample_count_q;
			endcase
		end
	end

	steim_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.words(words),
		.steim_version(steim_version_q),
		.queue_full(queue_full),
		.push(push),
		.cmd(push_cmd)
	);

	steim_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.full(queue_full),
		.head_valid(head_valid),
		.head(head)
	);

	steim_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.sample_count(sample_count_q),
		.samples(samples)
	);

endmodule
`default_nettype wire

// File: tb/steim_tb_pkg.sv
package steim_tb_pkg;

	typedef enum logic {
		STEIM1 = 1'b0,
		STEIM2 = 1'b1
	} steim_ver_t;

	localparam logic [1:0] NIB_EMPTY = 2'd0;
	localparam logic [1:0] NIB_BYTES = 2'd1;
	localparam logic [1:0] NIB_PAIR = 2'd2;
	localparam logic [1:0] NIB_WIDE = 2'd3;

	localparam logic [1:0] DNIB_BAD_PAIR = 2'd0;
	localparam logic [1:0] DNIB_ONE = 2'd1;
	localparam logic [1:0] DNIB_TWO = 2'd2;
	localparam logic [1:0] DNIB_THREE = 2'd3;

	localparam logic [1:0] DNIB_FIVE = 2'd0;
	localparam logic [1:0] DNIB_SIX = 2'd1;
	localparam logic [1:0] DNIB_SEVEN = 2'd2;
	localparam logic [1:0] DNIB_BAD_WIDE = 2'd3;

endpackage

// File: tb/steim_decoder_checker.sv
module steim_decoder_checker #(
	parameter int COUNT_BITS = steim_pkg::COUNT_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	steim_in_if words,
	steim_out_if samples,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output int fail_count,
	output int pending,
	output int sample_total,
	output int record_total
);
	import steim_pkg::*;
	import steim_tb_pkg::*;

	typedef struct packed {
		logic [31:0] sample;
		logic has_sample;
		logic record_done;
		logic [1:0] status;
	} sample_result_t;

	sample_result_t expected_q[$];
	sample_result_t oldest;
	steim_ver_t version;
	logic [15:0] sample_limit;
	logic [3:0] slot_count;
	logic first_frame;
	logic [31:0] ctrl_word;
	logic [31:0] start_sample;
	logic [31:0] last_sample;
	logic [COUNT_BITS-1:0] emitted;
	logic started;
	logic bad_seen;
	int fails;
	int samples_seen;
	int records_seen;

	function automatic logic [31:0] sign_extend(logic [31:0] raw, int bits);
		logic [31:0] mask;
		if (bits >= 32) return raw;
		mask = (32'd1 << bits) - 32'd1;
		raw = raw & mask;
		if (raw[bits-1]) raw = raw | ~mask;
		return raw;
	endfunction

	task automatic clear_record();
		slot_count = 4'd0;
		first_frame = 1'b1;
		ctrl_word = 32'd0;
		start_sample = 32'd0;
		last_sample = 32'd0;
		emitted = '0;
		started = 1'b0;
		bad_seen = 1'b0;
	endtask

	task automatic predict_word(input logic [31:0] word, input logic eor);
		sample_result_t burst [7];
		logic [1:0] nib;
		logic [31:0] value;
		status_t st;
		int made;
		int cnt;
		int bits;
		int top;
		int k;
		made = 0;
		cnt = 0;
		bits = 32;
		top = 32;
		if (!bad_seen) begin
			if (slot_count == 4'd0) begin
				ctrl_word = word;
			end else if (first_frame && slot_count == 4'd1) begin
				start_sample = word;
			end else if (!(first_frame && slot_count == 4'd2)) begin
				nib = ctrl_word[2 * (15 - int'(slot_count)) +: 2];
				if (nib != NIB_EMPTY && emitted < sample_limit) begin
					if (nib == NIB_BYTES) begin
						cnt = 4;
						bits = 8;
					end else if (version == STEIM1) begin
						if (nib == NIB_PAIR) begin
							cnt = 2;
							bits = 16;
						end else begin
							cnt = 1;
							bits = 32;
						end
					end else begin
						top = 30;
						case ({nib, word[31:30]})
							{NIB_PAIR, DNIB_ONE}: begin
								cnt = 1;
								bits = 30;
							end
							{NIB_PAIR, DNIB_TWO}: begin
								cnt = 2;
								bits = 15;
							end
							{NIB_PAIR, DNIB_THREE}: begin
								cnt = 3;
								bits = 10;
							end
							{NIB_WIDE, DNIB_FIVE}: begin
								cnt = 5;
								bits = 6;
							end
							{NIB_WIDE, DNIB_SIX}: begin
								cnt = 6;
								bits = 5;
							end
							{NIB_WIDE, DNIB_SEVEN}: begin
								cnt = 7;
								bits = 4;
								top = 28;
							end
							default: bad_seen = 1'b1;
						endcase
					end
					for (k = 0; k < cnt; k++) begin
						if (emitted < sample_limit && emitted != '1) begin
							if (!started) begin
								value = start_sample;
								started = 1'b1;
							end else begin
								value = last_sample
									+ sign_extend(word >> (top - bits * (k + 1)), bits);
							end
							last_sample = value;
							emitted++;
							burst[made] = {value, 1'b1, 1'b0, STATUS_OK};
							made++;
						end
					end
				end
			end
		end
		if (slot_count == 4'd15) first_frame = 1'b0;
		slot_count++;
		if (eor) begin
			if (bad_seen) st = STATUS_BAD_WORD;
			else if (emitted < sample_limit) st = STATUS_SHORT;
			else st = STATUS_OK;
			if (made == 0) begin
				burst[0] = {32'd0, 1'b0, 1'b0, STATUS_OK};
				made = 1;
			end
			burst[made-1].record_done = 1'b1;
			burst[made-1].status = st;
			clear_record();
		end
		for (k = 0; k < made; k++) expected_q.push_back(burst[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version = steim_ver_t'(VERSION_RESET);
			sample_limit = 16'(SAMPLE_COUNT_RESET);
			clear_record();
			expected_q.delete();
			fails = 0;
			samples_seen = 0;
			records_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_VERSION, 2'b00}) version = steim_ver_t'(pwdata[0]);
				else if (paddr == {REG_SAMPLE_COUNT, 2'b00}) sample_limit = pwdata[15:0];
			end
			if (words.valid && words.ready) begin
				predict_word(words.data_word, words.end_of_record);
			end
			if (samples.valid && samples.ready) begin
				if (expected_q.size() == 0) begin
					$error("result with nothing expected: sample %0d, has_sample %0b, record_done %0b",
						samples.sample, samples.has_sample, samples.record_done);
					fails++;
				end else begin
					oldest = expected_q.pop_front();
					if (samples.sample !== oldest.sample) begin
						$error("sample: expected %0d, actual %0d",
							$signed(oldest.sample), samples.sample);
						fails++;
					end
					if (samples.has_sample !== oldest.has_sample) begin
						$error("has_sample: expected %0b, actual %0b",
							oldest.has_sample, samples.has_sample);
						fails++;
					end
					if (samples.record_done !== oldest.record_done) begin
						$error("record_done: expected %0b, actual %0b",
							oldest.record_done, samples.record_done);
						fails++;
					end
					if (samples.status !== oldest.status) begin
						$error("status: expected %0d, actual %0d", oldest.status, samples.status);
						fails++;
					end
				end
				if (samples.has_sample) samples_seen++;
				if (samples.record_done) records_seen++;
			end
		end
		fail_count <= fails;
		pending <= expected_q.size();
		sample_total <= samples_seen;
		record_total <= records_seen;
	end

endmodule

// File: tb/tb_steim_record_decoder_top.sv
module tb_steim_record_decoder_top;
	import steim_pkg::*;
	import steim_tb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 64;
	localparam int STALL_CYCLES = 300;
	localparam int PHASE_WORDS = 16;
	localparam logic [2:0] ADDR_VERSION = {REG_VERSION, 2'b00};
	localparam logic [2:0] ADDR_SAMPLE_COUNT = {REG_SAMPLE_COUNT, 2'b00};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int sample_total;
	int record_total;
	int tx_idle_pct;
	int rx_idle_pct;
	int word_total;
	int cycle_count;
	bit stall_request;

	steim_in_if words_bus();
	steim_out_if samples_bus();

	steim_record_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.words(words_bus),
		.samples(samples_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	steim_decoder_checker sample_check (
		.clk(clk),
		.arst_n(arst_n),
		.words(words_bus),
		.samples(samples_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending(pending),
		.sample_total(sample_total),
		.record_total(record_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("[steim_record_decoder_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		samples_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				samples_bus.ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end
			samples_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic push_word(input logic [31:0] word, input logic eor);
		while ($urandom_range(99) < tx_idle_pct) begin
			words_bus.valid <= 1'b0;
			@(posedge clk);
		end
		words_bus.valid <= 1'b1;
		words_bus.data_word <= word;
		words_bus.end_of_record <= eor;
		@(posedge clk);
		while (!words_bus.ready) @(posedge clk);
		word_total++;
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		words_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [1:0] pick_dnib(logic [1:0] nib);
		case (nib)
			NIB_PAIR: return 2'($urandom_range(DNIB_THREE, DNIB_ONE));
			NIB_WIDE: return 2'($urandom_range(DNIB_SEVEN, DNIB_FIVE));
			default: return 2'($urandom_range(3, 0));
		endcase
	endfunction

	// Well-formed frames with random content; a tenth of the data words keep random
	// dnib bits, so Steim-2 records now and then hit a bad word.
	task automatic send_record(input int len);
		logic [31:0] ctrl;
		logic [31:0] word;
		int k;
		int slot;
		ctrl = 32'd0;
		for (k = 0; k < len; k++) begin
			slot = k % 16;
			word = $urandom();
			if (slot == 0) begin
				ctrl = word;
			end else if (k > 2 && $urandom_range(99) < 90) begin
				word[31:30] = pick_dnib(ctrl[2 * (15 - slot) +: 2]);
			end
			push_word(word, k == len - 1);
		end
	endtask

	initial begin
		steim_ver_t ver;
		logic [15:0] limit;
		int phase;
		int phase_words;
		int len;
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		words_bus.valid <= 1'b0;
		words_bus.data_word <= '0;
		words_bus.end_of_record <= 1'b0;
		tx_idle_pct = 11;
		rx_idle_pct = 48;
		word_total = 0;
		stall_request = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(ADDR_VERSION, {31'd0, STEIM2});
		reg_write(ADDR_SAMPLE_COUNT, 32'd40);
		// every Steim-2 format once, record ends mid-frame short of samples
		push_word({NIB_EMPTY, NIB_EMPTY, NIB_EMPTY, NIB_BYTES, NIB_PAIR, NIB_PAIR,
			NIB_PAIR, NIB_WIDE, NIB_WIDE, NIB_WIDE, 12'd0}, 1'b0);
		push_word(32'h8000_0000, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h7F80_01FF, 1'b0);
		push_word({DNIB_ONE, 30'h2000_0000}, 1'b0);
		push_word({DNIB_TWO, 15'h3FFF, 15'h4000}, 1'b0);
		push_word({DNIB_THREE, 10'h1FF, 10'h200, 10'h3FF}, 1'b0);
		push_word({DNIB_FIVE, 6'h1F, 6'h20, 6'h01, 6'h3F, 6'h00}, 1'b0);
		push_word({DNIB_SIX, 5'h0F, 5'h10, 5'h1F, 5'h01, 5'h00, 5'h11}, 1'b0);
		push_word({DNIB_SEVEN, 2'b11, 28'h78F1E09}, 1'b1);
		// bad dnib on a pair word
		push_word({NIB_EMPTY, NIB_EMPTY, NIB_EMPTY, NIB_PAIR, 24'd0}, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word({DNIB_BAD_PAIR, 30'h3FFF_FFFF}, 1'b1);
		// bad dnib on a wide word
		push_word({NIB_EMPTY, NIB_EMPTY, NIB_EMPTY, NIB_WIDE, 24'd0}, 1'b0);
		push_word(32'h1234_5678, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word({DNIB_BAD_WIDE, 30'h0000_0001}, 1'b1);
		settle();

		reg_write(ADDR_VERSION, {31'd0, STEIM1});
		reg_write(ADDR_SAMPLE_COUNT, 32'd7);
		// Steim-1 formats with wrap past the positive extreme, exact sample count
		push_word({NIB_EMPTY, NIB_EMPTY, NIB_EMPTY, NIB_BYTES, NIB_PAIR, NIB_WIDE,
			20'd0}, 1'b0);
		push_word(32'h7FFF_FFFF, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h80FF_7F01, 1'b0);
		push_word(32'hFFFF_8000, 1'b0);
		push_word(32'h8000_0000, 1'b1);

		for (phase = 0; phase < 8; phase++) begin
			settle();
			if (phase == 3) begin
				tx_idle_pct = 48;
				rx_idle_pct = 11;
			end
			if (phase == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			ver = steim_ver_t'(phase % 2);
			case (phase)
				0: limit = 16'd1;
				1: limit = 16'hFFFF;
				2: limit = 16'd0;
				default: limit = 16'($urandom_range(80, 2));
			endcase
			reg_write(ADDR_VERSION, {31'd0, ver});
			reg_write(ADDR_SAMPLE_COUNT, {16'd0, limit});
			if (phase == 6) stall_request = 1'b1;
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				if ($urandom_range(99) < 30) len = $urandom_range(36, 17);
				else len = $urandom_range(16, 1);
				send_record(len);
				phase_words += len;
			end
		end
		settle();

		$display("covered %0d record words in %0d records, %0d samples checked,",
			word_total, record_total, sample_total);
		$display("Steim-1 and Steim-2, sample_count 0 to 65535, idle and long-stall phases");
		if (fail_count == 0) begin
			$display("[steim_record_decoder_top] OK");
		end else begin
			$display("[steim_record_decoder_top] ERROR");
		end
		$finish;
	end

endmodule
